[rtl/hmsr_pkg.sv]
package hmsr_pkg;

  localparam int TOK_ROWS  = 16;
  localparam int TOK_BYTES = 16;

  localparam logic [1:0] ROUTE_UNDECIDED = 2'd0;
  localparam logic [1:0] ROUTE_WEB       = 2'd1;
  localparam logic [1:0] ROUTE_TUNNEL    = 2'd2;

  // Method tokens, right-justified: the first character sits in the highest used byte.
  localparam logic [8*TOK_BYTES-1:0] TOK_TEXT [TOK_ROWS] = '{
    128'("GET "), 128'("POST "), 128'("PUT "), 128'("HEAD "), 128'("DELETE "),
    128'("OPTIONS "), 128'("PATCH "), 128'("TRACE "), 128'("CONNECT "), 128'("PRI "),
    128'h0, 128'h0, 128'h0, 128'h0, 128'h0, 128'h0
  };

  // A length of zero marks an unused row that never matches.
  localparam logic [4:0] TOK_LEN [TOK_ROWS] = '{
    5'd4, 5'd5, 5'd4, 5'd5, 5'd7, 5'd8, 5'd6, 5'd6, 5'd8, 5'd4,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
  };

  typedef struct packed {
    logic full_hit;
    logic any_alive;
  } match_sts_t;

endpackage

[rtl/hmsr_match.sv]
module hmsr_match #(
  parameter int NUM_TOKENS    = 10,
  parameter int MAX_TOKEN_LEN = 8
) (
  input  logic [7:0]              data_byte,
  input  logic [7:0]              pos,
  input  logic [NUM_TOKENS-1:0]   mask_in,
  output logic [NUM_TOKENS-1:0]   mask_out,
  output hmsr_pkg::match_sts_t    sts
);
  import hmsr_pkg::*;

  logic [NUM_TOKENS-1:0] full_vec;

  always_comb begin
    logic [3:0] off;
    logic [7:0] chr;
    logic       in_range;
    mask_out = '0;
    full_vec = '0;
    for (int i = 0; i < NUM_TOKENS; i++) begin
      // pos is below the token length here whenever it matters, so it fits in four bits
      off      = 4'(TOK_LEN[i] - 5'd1 - {1'b0, pos[3:0]});
      chr      = TOK_TEXT[i][{off, 3'b000} +: 8];
      in_range = (pos < {3'b000, TOK_LEN[i]}) && (pos < 8'(MAX_TOKEN_LEN));
      if (mask_in[i] && in_range && (chr == data_byte)) begin
        mask_out[i] = 1'b1;
        full_vec[i] = (pos == ({3'b000, TOK_LEN[i]} - 8'd1));
      end
    end
  end

  assign sts.full_hit  = |full_vec;
  assign sts.any_alive = |mask_out;

endmodule

[rtl/http_method_sniff_router.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   data_byte, starts_connection, ends_chunk
// out_      output     out_valid / out_stall data_out, route, decided_now
// cfg_      input      cfg_wr_en             decide_threshold
//
// One beat per cycle unless out_stall holds; a beat passes the input and then the output register.
// The token compare and route decision run combinationally between the input register
// and the output register, together with the connection state update.
// rst_n (synchronous, active low) clears the connection state and sets the threshold to 16.
// out_stall holds the output register; the input register then fills and raises in_stall.
module http_method_sniff_router #(
  parameter int NUM_TOKENS    = 10,
  parameter int MAX_TOKEN_LEN = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_starts_connection,
  input  logic       in_ends_chunk,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic [1:0] out_route,
  output logic       out_decided_now,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_decide_threshold
);
  import hmsr_pkg::*;

  logic [7:0]            thresh_r;
  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_start_r;
  logic                  s1_end_r;
  logic [NUM_TOKENS-1:0] mask_r, mask_nxt;
  logic                  full_r, full_nxt;
  logic [7:0]            cnt_r, cnt_nxt;
  logic [1:0]            route_r, route_nxt;
  logic                  dec_nxt;
  logic                  out_valid_r;
  logic [7:0]            out_data_r;
  logic [1:0]            out_route_r;
  logic                  out_dec_r;

  logic                  out_free;
  logic                  advance;
  logic                  in_take;
  logic [NUM_TOKENS-1:0] eff_mask;
  logic [NUM_TOKENS-1:0] match_mask;
  logic [7:0]            eff_cnt;
  match_sts_t            msts;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // A connection-start beat sees cleared state.
  assign eff_mask = s1_start_r ? {NUM_TOKENS{1'b1}} : mask_r;
  assign eff_cnt  = s1_start_r ? 8'd0 : cnt_r;

  hmsr_match #(
    .NUM_TOKENS   (NUM_TOKENS),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_match (
    .data_byte(s1_byte_r),
    .pos      (eff_cnt),
    .mask_in  (eff_mask),
    .mask_out (match_mask),
    .sts      (msts)
  );

  always_comb begin
    logic eff_full;
    logic [1:0] eff_route;
    eff_full  = s1_start_r ? 1'b0 : full_r;
    eff_route = s1_start_r ? ROUTE_UNDECIDED : route_r;
    mask_nxt  = eff_mask;
    full_nxt  = eff_full;
    cnt_nxt   = eff_cnt;
    route_nxt = eff_route;
    dec_nxt   = 1'b0;
    if (eff_route == ROUTE_UNDECIDED) begin
      mask_nxt = match_mask;
      full_nxt = eff_full | msts.full_hit;
      cnt_nxt  = (eff_cnt == 8'hFF) ? eff_cnt : eff_cnt + 8'd1;
      if (s1_end_r) begin
        if (full_nxt) begin
          route_nxt = ROUTE_WEB;
          dec_nxt   = 1'b1;
        end else if (!(msts.any_alive && (cnt_nxt < thresh_r))) begin
          route_nxt = ROUTE_TUNNEL;
          dec_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= 8'd16;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= {NUM_TOKENS{1'b1}};
      full_r      <= 1'b0;
      cnt_r       <= 8'd0;
      route_r     <= ROUTE_UNDECIDED;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_decide_threshold;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        mask_r      <= mask_nxt;
        full_r      <= full_nxt;
        cnt_r       <= cnt_nxt;
        route_r     <= route_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: load the input beat when taken, the result when advanced.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_starts_connection;
      s1_end_r   <= in_ends_chunk;
    end
    if (advance) begin
      out_data_r  <= s1_byte_r;
      out_route_r <= route_nxt;
      out_dec_r   <= dec_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_route       = out_route_r;
  assign out_decided_now = out_dec_r;

endmodule
